// ===== sv/swm_pkg.sv =====
// Shared types, sizes and cell bundles for the sliding window median filter.
package swm_pkg;

	localparam int WINDOW_MAX  = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int CFG_W       = 6;
	localparam int LEN_W       = $clog2(WINDOW_MAX + 1);
	localparam int POS_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [LEN_W-1:0]              len_t;
	typedef logic [POS_W-1:0]              pos_t;
	typedef logic [CFG_W-1:0]              cfg_t;

	typedef enum logic {
		REQ_PRELOAD = 1'b0,
		REQ_PUSH    = 1'b1
	} req_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic    upd;
		logic    push;
		len_t    n_valid;
		pos_t    rem_tag;
		pos_t    new_tag;
		sample_t s;
	} cell_cmd_t;

	// Handed from a cell to its higher neighbor.
	typedef struct packed {
		logic    r;
		logic    gc;
		sample_t v;
		pos_t    tag;
	} cell_up_t;

	// Handed from a cell to its lower neighbor.
	typedef struct packed {
		sample_t v;
		pos_t    tag;
		logic    gtp;
	} cell_dn_t;

endpackage

// ===== sv/swm_ifs.sv =====
// Valid/ready channel interfaces for the input and result words.
interface swm_in_if;
	logic            valid;
	logic            ready;
	swm_pkg::req_t   req_type;
	swm_pkg::sample_t sample;

	modport source (output valid, output req_type, output sample, input ready);
	modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface swm_out_if;
	logic             valid;
	logic             ready;
	swm_pkg::sample_t median;
	logic             window_full;
	logic             rejected;

	modport source (output valid, output median, output window_full, output rejected,
		input ready);
	modport sink   (input valid, input median, input window_full, input rejected,
		output ready);
endinterface

// ===== sv/swm_cell.sv =====
// One cell of the sorted row: holds a sample and its ring position tag.
module swm_cell (
	input  logic               clk,
	input  swm_pkg::cell_cmd_t cmd,
	input  swm_pkg::pos_t      idx,
	input  swm_pkg::cell_up_t  lo,
	input  swm_pkg::cell_dn_t  hi,
	output swm_pkg::cell_up_t  up,
	output swm_pkg::cell_dn_t  dn
);

	swm_pkg::sample_t v_q;
	swm_pkg::pos_t    tag_q;

	logic             in_win;
	logic             gtp;
	logic             rem;
	logic             r;
	logic             gc;
	swm_pkg::sample_t cv;
	swm_pkg::pos_t    ctag;

	// Cells past the occupied part act as +infinity.
	assign in_win = swm_pkg::len_t'(idx) < cmd.n_valid;
	assign gtp    = ~in_win | (v_q > cmd.s);
	assign rem    = cmd.push & in_win & (tag_q == cmd.rem_tag);
	assign r      = lo.r | rem;
	// After the removed entry, the row is seen shifted down by one.
	assign gc     = r ? hi.gtp : gtp;
	assign cv     = r ? hi.v   : v_q;
	assign ctag   = r ? hi.tag : tag_q;

	assign up = '{r: r, gc: gc, v: cv, tag: ctag};
	assign dn = '{v: v_q, tag: tag_q, gtp: gtp};

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			if (!gc) begin
				v_q   <= cv;
				tag_q <= ctag;
			end else if (lo.gc) begin
				v_q   <= lo.v;
				tag_q <= lo.tag;
			end else begin
				v_q   <= cmd.s;
				tag_q <= cmd.new_tag;
			end
		end
	end

endmodule

// ===== sv/sliding_window_median.sv =====
// Top level of the sliding window median filter: control, cell row and result stage.
//
// The window is kept as a row of WINDOW_MAX cells in ascending order. Each cell
// holds one sample and the ring position it was written to, which stands in for
// the arrival-order ring: a push removes the cell tagged with the oldest position
// and inserts the new sample, tagged with that same position, in sorted order.
// Every cell compares its sample with the incoming one and takes its new content
// from itself or from a neighbor, so a whole update finishes in the cycle the word
// is accepted; the only long path is the removal flag that ripples up the row.
// One word is accepted per cycle as long as results are taken. For each result the
// row updates at the accepting edge; once the output register is free or drained,
// sorted[window_len/2] is selected into that output register. The median
// reads 0 and window_full 0 until window_len preload words have arrived; a push
// before that is answered with rejected set and changes nothing. A preload into a
// full window starts a new load. Writing window_len (0 reads as 1, values above
// WINDOW_MAX saturate) restarts the load and must only happen while the block is
// idle. There is no clearing pass after reset: cells that were never loaded are
// never selected.
module sliding_window_median (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  swm_pkg::cfg_t   cfg_wdata,
	swm_in_if.sink          samples,
	swm_out_if.source       results
);

	swm_pkg::len_t len_q;
	swm_pkg::len_t lc_q;
	swm_pkg::pos_t op_q;

	logic             res_valid_s1;
	logic             res_full_s1;
	logic             res_rej_s1;

	logic             out_valid_q;
	swm_pkg::sample_t out_median_q;
	logic             out_full_q;
	logic             out_rej_q;

	logic               acc;
	logic               full_now;
	logic               is_push;
	logic               rej;
	swm_pkg::len_t      base;
	swm_pkg::len_t      base_inc;
	swm_pkg::len_t      op_inc;
	logic               s1_go;
	swm_pkg::cell_cmd_t cmd;
	swm_pkg::pos_t      mid;
	swm_pkg::len_t      len_new;

	swm_pkg::cell_up_t up_w [swm_pkg::WINDOW_MAX];
	swm_pkg::cell_dn_t dn_w [swm_pkg::WINDOW_MAX];

	// The result stage moves on whenever the output register is free or drained.
	// A new word may enter only when the median of the previous one is taken from
	// the row in the same cycle, since the row is overwritten at that edge.
	assign s1_go         = ~out_valid_q | results.ready;
	assign samples.ready = ~res_valid_s1 | s1_go;
	assign acc           = samples.valid & samples.ready;

	assign full_now = lc_q == len_q;
	assign is_push  = samples.req_type == swm_pkg::REQ_PUSH;
	assign rej      = is_push & ~full_now;
	assign base     = full_now ? '0 : lc_q;
	assign base_inc = base + swm_pkg::len_t'(1);
	assign op_inc   = swm_pkg::len_t'(op_q) + swm_pkg::len_t'(1);

	// A preload inserts into the first base cells; a push removes the oldest
	// entry among window_len cells and inserts the new sample.
	always_comb begin
		cmd.upd     = acc & ~rej;
		cmd.push    = is_push;
		cmd.n_valid = is_push ? len_q : base;
		cmd.rem_tag = op_q;
		cmd.new_tag = is_push ? op_q : swm_pkg::pos_t'(base);
		cmd.s       = samples.sample;
	end

	// Register write: zero means one, anything above the row length saturates.
	always_comb begin
		if (cfg_wdata == '0) begin
			len_new = swm_pkg::len_t'(1);
		end else if (int'(cfg_wdata) > swm_pkg::WINDOW_MAX) begin
			len_new = swm_pkg::len_t'(swm_pkg::WINDOW_MAX);
		end else begin
			len_new = swm_pkg::len_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= swm_pkg::len_t'(swm_pkg::WINDOW_MAX);
			lc_q  <= '0;
			op_q  <= '0;
		end else if (cfg_we) begin
			len_q <= len_new;
			lc_q  <= '0;
			op_q  <= '0;
		end else if (acc && !rej) begin
			if (is_push) begin
				op_q <= (op_inc >= len_q) ? '0 : swm_pkg::pos_t'(op_inc);
			end else begin
				lc_q <= base_inc;
				if (full_now) begin
					op_q <= '0;
				end
			end
		end
	end

	// Result flags travel one stage while the row settles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (acc) begin
			res_valid_s1 <= 1'b1;
		end else if (s1_go) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_full_s1 <= is_push ? ~rej : (base_inc == len_q);
			res_rej_s1  <= rej;
		end
	end

	// The row is one chain: each cell sees its two neighbors, the ends see
	// an empty cell below and a +infinity cell above.
	for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
		swm_pkg::cell_up_t lo_in;
		swm_pkg::cell_dn_t hi_in;

		if (i == 0) begin : g_lo_end
			assign lo_in = '{r: 1'b0, gc: 1'b0, v: '0, tag: '0};
		end else begin : g_lo_mid
			assign lo_in = up_w[i-1];
		end

		if (i == swm_pkg::WINDOW_MAX - 1) begin : g_hi_end
			assign hi_in = '{v: '0, tag: '0, gtp: 1'b1};
		end else begin : g_hi_mid
			assign hi_in = dn_w[i+1];
		end

		swm_cell u_cell (
			.clk (clk),
			.cmd (cmd),
			.idx (swm_pkg::pos_t'(i)),
			.lo  (lo_in),
			.hi  (hi_in),
			.up  (up_w[i]),
			.dn  (dn_w[i])
		);
	end

	assign mid = swm_pkg::pos_t'(len_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= res_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_valid_s1) begin
			out_median_q <= res_full_s1 ? dn_w[mid].v : '0;
			out_full_q   <= res_full_s1;
			out_rej_q    <= res_rej_s1;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.median      = out_median_q;
	assign results.window_full = out_full_q;
	assign results.rejected    = out_rej_q;

	// The load count never runs past the window length.
	a_lc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= len_q)
		else $error("load count above window length");

	// The oldest position always points inside the window.
	a_op_bound: assert property (@(posedge clk) disable iff (!arst_n)
		op_q < len_q)
		else $error("oldest position outside window");

	// A stalled result stage must hold off new words, or the row would move on.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && !s1_go |-> !samples.ready)
		else $error("word accepted while median not yet taken");

	// An early push comes back rejected and not full.
	a_early_push: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_push && (lc_q != len_q) |=> res_rej_s1 && !res_full_s1)
		else $error("early push not rejected");

endmodule
